[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers with a synchronous active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check prop on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that ante implies cons in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that ante implies cons in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/ttc_pkg.sv]
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants of the text terminal cursor controller.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int COLUMNS = 32;
    localparam int ROWS    = 24;

    localparam int COL_W   = 5;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int COORD_W = 8;
    localparam int OP_W    = 3;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_SHOWN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_VIDEO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ENABLE = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT_CHAR = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_CLEAR_HOME = 2'd2,
        CMD_BLINK = 2'd3
    } t_cmd;

    typedef enum logic [OP_W-1:0] {
        OP_NONE = 3'd0,
        OP_DRAW = 3'd1,
        OP_CLEAR_CELL = 3'd2,
        OP_SCROLL = 3'd3,
        OP_CLEAR_SCREEN = 3'd4,
        OP_TOGGLE_UL = 3'd5
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
    } t_ctl;

    typedef struct packed {
        logic last;
        logic slot_free;
    } t_stat;

endpackage

[hw/rtl/ttc_cmd_if.sv]
// ----------------------------------------------------------------------------
// ttc_cmd_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface ttc_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [ttc_pkg::CMD_W-1:0]   cmd;
    logic [ttc_pkg::CHAR_W-1:0]  char_code;
    logic [ttc_pkg::COORD_W-1:0] target_col;
    logic [ttc_pkg::COORD_W-1:0] target_row;

    modport source (output valid, cmd, char_code, target_col, target_row, input ready);
    modport sink (input valid, cmd, char_code, target_col, target_row, output ready);
endinterface

[hw/rtl/ttc_op_if.sv]
// ----------------------------------------------------------------------------
// ttc_op_if
// Cell operation channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface ttc_op_if;
    logic                      valid;
    logic                      ready;
    logic [ttc_pkg::OP_W-1:0]   op;
    logic [ttc_pkg::COL_W-1:0]  cell_col;
    logic [ttc_pkg::ROW_W-1:0]  cell_row;
    logic [ttc_pkg::CHAR_W-1:0] glyph_code;
    logic                      invert;
    logic [ttc_pkg::COL_W-1:0]  cursor_col_now;
    logic [ttc_pkg::ROW_W-1:0]  cursor_row_now;
    logic                      last;

    modport source (output valid, op, cell_col, cell_row, glyph_code, invert,
                    cursor_col_now, cursor_row_now, last, input ready);
    modport sink (input valid, op, cell_col, cell_row, glyph_code, invert,
                  cursor_col_now, cursor_row_now, last, output ready);
endinterface

[hw/rtl/text_terminal_cursor_control.sv]
// ----------------------------------------------------------------------------
// text_terminal_cursor_control
// Character-cell terminal controller: turns commands into cell operations.
// ----------------------------------------------------------------------------
// Channel   Dir  Transaction
// i_cmd     in   one command: cmd, char_code, target_col, target_row
// o_op      out  one cell operation, last set on the final one of a command
// i_cfg_*   in   register write: index and one data bit, no back-pressure
//
// A command is latched when it is taken, then the sequencer produces one operation
// per step into the output register: one for most commands, up to five for a tab
// (four draws and a scroll). The sequencer steps only when the output
// register is empty or being taken, so o_op back-pressure stalls the run.
// A new command is taken once the last operation of the previous one is in
// the output register. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_terminal_cursor_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ttc_cmd_if.sink                           i_cmd,
    ttc_op_if.source                          o_op,
    input  logic                              i_cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    ttc_pkg::t_ctl  s_ctl;
    ttc_pkg::t_stat s_stat;
    logic           s_in_ready;

    assign i_cmd.ready = s_in_ready;

    ttc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (s_in_ready),
        .i_stat     (s_stat),
        .o_ctl      (s_ctl)
    );

    ttc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (s_ctl),
        .o_stat           (s_stat),
        .i_cmd            (i_cmd.cmd),
        .i_char_code      (i_cmd.char_code),
        .i_target_col     (i_cmd.target_col),
        .i_target_row     (i_cmd.target_row),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_op.valid),
        .i_out_ready      (o_op.ready),
        .o_op             (o_op.op),
        .o_cell_col       (o_op.cell_col),
        .o_cell_row       (o_op.cell_row),
        .o_glyph_code     (o_op.glyph_code),
        .o_invert         (o_op.invert),
        .o_cursor_col_now (o_op.cursor_col_now),
        .o_cursor_row_now (o_op.cursor_row_now),
        .o_last           (o_op.last)
    );

    `ASSERT_IMPLIES(a_cursor_range, i_clk, i_rst_n, o_op.valid,
        (o_op.cursor_row_now <= ttc_pkg::ROW_LAST) && (o_op.cursor_col_now <= ttc_pkg::COL_LAST))
    `ASSERT_IMPLIES(a_scroll_no_cell, i_clk, i_rst_n, o_op.valid && (o_op.op == ttc_pkg::OP_SCROLL),
        (o_op.cell_col == '0) && (o_op.cell_row == '0) && !o_op.invert)
    `ASSERT_NEXT(a_run_holds_input, i_clk, i_rst_n, s_ctl.step && !s_stat.last, !i_cmd.ready)
    `ASSERT_NEXT(a_accept_closes, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready)

endmodule

[hw/rtl/ttc_ctrl.sv]
// ----------------------------------------------------------------------------
// ttc_ctrl
// Sequencer: takes a command, then steps the datapath once per operation.
// ----------------------------------------------------------------------------
module ttc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ttc_pkg::t_stat  i_stat,
    output ttc_pkg::t_ctl   o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_comb begin
        o_ctl.load = (r_state == S_IDLE) && r_in_ready && i_in_valid;
        o_ctl.step = (r_state == S_RUN) && i_stat.slot_free;
    end

    assign o_in_ready = r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_in_ready && i_in_valid) begin
                        r_state    <= S_RUN;
                        r_in_ready <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (i_stat.slot_free && i_stat.last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

[hw/rtl/ttc_dp.sv]
// ----------------------------------------------------------------------------
// ttc_dp
// Datapath: cursor, settings, latched command and the output register.
// ----------------------------------------------------------------------------
module ttc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ttc_pkg::t_ctl               i_ctl,
    output ttc_pkg::t_stat              o_stat,
    input  logic [ttc_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ttc_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [ttc_pkg::COORD_W-1:0] i_target_col,
    input  logic [ttc_pkg::COORD_W-1:0] i_target_row,
    input  logic                        i_cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [ttc_pkg::OP_W-1:0]    o_op,
    output logic [ttc_pkg::COL_W-1:0]   o_cell_col,
    output logic [ttc_pkg::ROW_W-1:0]   o_cell_row,
    output logic [ttc_pkg::CHAR_W-1:0]  o_glyph_code,
    output logic                        o_invert,
    output logic [ttc_pkg::COL_W-1:0]   o_cursor_col_now,
    output logic [ttc_pkg::ROW_W-1:0]   o_cursor_row_now,
    output logic                        o_last
);

    // settings
    logic r_cursor_shown;
    logic r_invert_video;
    logic r_wrap_enable;
    logic r_scroll_enable;

    // cursor and command
    logic [ttc_pkg::COL_W-1:0]   r_col;
    logic [ttc_pkg::ROW_W-1:0]   r_row;
    ttc_pkg::t_cmd               r_cmd;
    logic [ttc_pkg::CHAR_W-1:0]  r_char;
    logic [ttc_pkg::COORD_W-1:0] r_tcol;
    logic [ttc_pkg::COORD_W-1:0] r_trow;
    logic                        r_pend_scroll;

    // output register
    logic                        r_out_valid;
    ttc_pkg::t_op                r_op;
    logic [ttc_pkg::COL_W-1:0]   r_cell_col;
    logic [ttc_pkg::ROW_W-1:0]   r_cell_row;
    logic [ttc_pkg::CHAR_W-1:0]  r_glyph;
    logic                        r_invert;
    logic [ttc_pkg::COL_W-1:0]   r_cur_col;
    logic [ttc_pkg::ROW_W-1:0]   r_cur_row;
    logic                        r_last;

    // step results
    ttc_pkg::t_op                n_op;
    logic [ttc_pkg::COL_W-1:0]   n_cell_col;
    logic [ttc_pkg::ROW_W-1:0]   n_cell_row;
    logic [ttc_pkg::CHAR_W-1:0]  n_glyph;
    logic                        n_invert;
    logic [ttc_pkg::COL_W-1:0]   n_col;
    logic [ttc_pkg::ROW_W-1:0]   n_row;
    logic                        n_last;
    logic                        n_pend_scroll;

    logic [ttc_pkg::COL_W:0]     w_col_inc;
    logic [ttc_pkg::ROW_W:0]     w_row_inc;
    logic [ttc_pkg::ROW_W-1:0]   w_lf_row;
    logic                        w_lf_scroll;
    logic [ttc_pkg::COL_W-1:0]   w_adv_col;
    logic [ttc_pkg::ROW_W-1:0]   w_adv_row;
    logic                        w_adv_scroll;
    logic                        w_tab_stuck;

    // line feed and column advance
    always_comb begin
        w_col_inc = {1'b0, r_col} + 1'b1;
        w_row_inc = {1'b0, r_row} + 1'b1;

        if (w_row_inc >= (ttc_pkg::ROW_W + 1)'(ttc_pkg::ROWS)) begin
            w_lf_row    = ttc_pkg::ROW_LAST;
            w_lf_scroll = r_scroll_enable;
        end else begin
            w_lf_row    = w_row_inc[ttc_pkg::ROW_W-1:0];
            w_lf_scroll = 1'b0;
        end

        w_adv_row    = r_row;
        w_adv_scroll = 1'b0;
        if (w_col_inc >= (ttc_pkg::COL_W + 1)'(ttc_pkg::COLUMNS)) begin
            if (r_wrap_enable) begin
                w_adv_col    = '0;
                w_adv_row    = w_lf_row;
                w_adv_scroll = w_lf_scroll;
            end else begin
                w_adv_col = ttc_pkg::COL_LAST;
            end
        end else begin
            w_adv_col = w_col_inc[ttc_pkg::COL_W-1:0];
        end

        w_tab_stuck = !r_wrap_enable && (r_col >= ttc_pkg::COL_LAST);
    end

    // one operation per step
    always_comb begin
        n_op          = ttc_pkg::OP_NONE;
        n_cell_col    = '0;
        n_cell_row    = '0;
        n_glyph       = '0;
        n_invert      = 1'b0;
        n_col         = r_col;
        n_row         = r_row;
        n_last        = 1'b1;
        n_pend_scroll = 1'b0;

        if (r_pend_scroll) begin
            n_op = ttc_pkg::OP_SCROLL;
        end else begin
            unique case (r_cmd)
                ttc_pkg::CMD_PUT_CHAR: begin
                    unique case (r_char)
                        ttc_pkg::CHAR_LF: begin
                            n_col = '0;
                            n_row = w_lf_row;
                            if (w_lf_scroll) begin
                                n_op = ttc_pkg::OP_SCROLL;
                            end
                        end
                        ttc_pkg::CHAR_CR: begin
                            n_col = '0;
                        end
                        ttc_pkg::CHAR_BS: begin
                            if (r_col != '0) begin
                                n_col      = r_col - 1'b1;
                                n_op       = ttc_pkg::OP_CLEAR_CELL;
                                n_cell_col = r_col - 1'b1;
                                n_cell_row = r_row;
                                n_invert   = r_invert_video;
                            end
                        end
                        default: begin
                            n_op          = ttc_pkg::OP_DRAW;
                            n_cell_col    = r_col;
                            n_cell_row    = r_row;
                            n_invert      = r_invert_video;
                            n_col         = w_adv_col;
                            n_row         = w_adv_row;
                            n_pend_scroll = w_adv_scroll;
                            if (r_char == ttc_pkg::CHAR_TAB) begin
                                n_glyph = ttc_pkg::CHAR_SPACE;
                                n_last  = w_adv_scroll || w_tab_stuck ||
                                          (w_adv_col[1:0] == 2'b00);
                            end else begin
                                n_glyph = r_char;
                                n_last  = 1'b1;
                            end
                            if (w_adv_scroll) begin
                                n_last = 1'b0;
                            end
                        end
                    endcase
                end
                ttc_pkg::CMD_SET_CURSOR: begin
                    if (r_tcol < ttc_pkg::COORD_W'(ttc_pkg::COLUMNS)) begin
                        n_col = r_tcol[ttc_pkg::COL_W-1:0];
                    end
                    if (r_trow < ttc_pkg::COORD_W'(ttc_pkg::ROWS)) begin
                        n_row = r_trow[ttc_pkg::ROW_W-1:0];
                    end
                end
                ttc_pkg::CMD_CLEAR_HOME: begin
                    n_op  = ttc_pkg::OP_CLEAR_SCREEN;
                    n_col = '0;
                    n_row = '0;
                end
                ttc_pkg::CMD_BLINK: begin
                    if (r_cursor_shown) begin
                        n_op       = ttc_pkg::OP_TOGGLE_UL;
                        n_cell_col = r_col;
                        n_cell_row = r_row;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_stat.last      = n_last;
        o_stat.slot_free = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_shown  <= 1'b1;
            r_invert_video  <= 1'b0;
            r_wrap_enable   <= 1'b1;
            r_scroll_enable <= 1'b1;
            r_col           <= '0;
            r_row           <= '0;
            r_pend_scroll   <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ttc_pkg::CFG_CURSOR_SHOWN:  r_cursor_shown  <= i_cfg_data[0];
                    ttc_pkg::CFG_INVERT_VIDEO:  r_invert_video  <= i_cfg_data[0];
                    ttc_pkg::CFG_WRAP_ENABLE:   r_wrap_enable   <= i_cfg_data[0];
                    ttc_pkg::CFG_SCROLL_ENABLE: r_scroll_enable <= i_cfg_data[0];
                endcase
            end
            if (i_ctl.step) begin
                r_col         <= n_col;
                r_row         <= n_row;
                r_pend_scroll <= n_pend_scroll;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= ttc_pkg::t_cmd'(i_cmd);
            r_char <= i_char_code;
            r_tcol <= i_target_col;
            r_trow <= i_target_row;
        end
        if (i_ctl.step) begin
            r_op       <= n_op;
            r_cell_col <= n_cell_col;
            r_cell_row <= n_cell_row;
            r_glyph    <= n_glyph;
            r_invert   <= n_invert;
            r_cur_col  <= n_col;
            r_cur_row  <= n_row;
            r_last     <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_op             = r_op;
    assign o_cell_col       = r_cell_col;
    assign o_cell_row       = r_cell_row;
    assign o_glyph_code     = r_glyph;
    assign o_invert         = r_invert;
    assign o_cursor_col_now = r_cur_col;
    assign o_cursor_row_now = r_cur_row;
    assign o_last           = r_last;

endmodule
